// File: rtl/plba_pkg.sv
package plba_pkg;

    localparam int CoordW  = 32;
    localparam int DiffW   = CoordW + 1;
    localparam int DistW   = DiffW + 1;
    localparam int AccW    = 48;
    localparam int CfgIdxW = 8;

    localparam logic [1:0] BoxMinX = 2'd0;
    localparam logic [1:0] BoxMaxX = 2'd1;
    localparam logic [1:0] BoxMinY = 2'd2;
    localparam logic [1:0] BoxMaxY = 2'd3;

    localparam logic [CfgIdxW-1:0] CfgLast = CfgIdxW'(3);

    typedef struct packed {
        logic signed [CoordW-1:0] point_x;
        logic signed [CoordW-1:0] point_y;
        logic                     curve_start;
    } t_in_item;

    typedef struct packed {
        logic [AccW-1:0]          current_length;
        logic [AccW-1:0]          curve_total;
        logic [AccW-1:0]          idle_total;
        logic signed [CoordW-1:0] box_min_x;
        logic signed [CoordW-1:0] box_max_x;
        logic signed [CoordW-1:0] box_min_y;
        logic signed [CoordW-1:0] box_max_y;
    } t_out_item;

endpackage

// File: rtl/polyline_length_bbox_accumulator.sv
// channel  valid        ready        payload
// in       i_in_valid   o_in_ready   i_in_data  (plba_pkg::t_in_item)
// out      o_out_valid  i_out_ready  o_out_data (plba_pkg::t_out_item)
// cfg      i_cfg_valid  o_cfg_ready  i_cfg_index, i_cfg_data
//
// A point after an earlier point is accepted, then goes through the bit-serial
// squares of dx and dy and the two-bits-per-step root; the done flag follows,
// then the result load.
// The very first point needs no distance and goes straight to the result load.
// Reset is synchronous and loads the box corners with the default seeds.
// A new item is taken while a finished result waits in the output register;
// a result that finds that register full holds until it is taken.
module polyline_length_bbox_accumulator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  plba_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output plba_pkg::t_out_item               o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [plba_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [plba_pkg::CoordW-1:0]       i_cfg_data
);

    localparam int CW = plba_pkg::CoordW;
    localparam int DW = plba_pkg::DiffW;
    localparam int RW = plba_pkg::DistW;
    localparam int AW = plba_pkg::AccW;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIST = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                  r_state, n_state;
    logic signed [CW-1:0]    r_last_x, r_last_y;
    logic                    r_have_point;
    logic                    r_had, r_start;
    logic [AW-1:0]           r_len, r_sum, r_idle, n_len, n_sum, n_idle;
    logic signed [CW-1:0]    r_box [4];
    logic                    r_out_valid;
    plba_pkg::t_out_item     r_out;

    logic                    w_acc_in, w_load;
    logic signed [DW-1:0]    w_px, w_py, w_lx, w_ly;
    logic signed [DW-1:0]    w_dxab, w_dxba, w_dyab, w_dyba;
    logic [DW-1:0]           w_dx, w_dy;
    logic                    w_dist_start, w_dist_done;
    logic [RW-1:0]           w_dist;

    function automatic logic [AW-1:0] sat_add(input logic [AW-1:0] a,
                                              input logic [RW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + (AW + 1)'(b);
        return s[AW] ? '1 : s[AW-1:0];
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_acc_in    = i_in_valid && o_in_ready;

    assign w_px   = {i_in_data.point_x[CW-1], i_in_data.point_x};
    assign w_py   = {i_in_data.point_y[CW-1], i_in_data.point_y};
    assign w_lx   = {r_last_x[CW-1], r_last_x};
    assign w_ly   = {r_last_y[CW-1], r_last_y};
    assign w_dxab = w_px - w_lx;
    assign w_dxba = w_lx - w_px;
    assign w_dyab = w_py - w_ly;
    assign w_dyba = w_ly - w_py;
    assign w_dx   = w_dxab[DW-1] ? w_dxba : w_dxab;
    assign w_dy   = w_dyab[DW-1] ? w_dyba : w_dyab;

    assign w_dist_start = w_acc_in && r_have_point;

    plba_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dist_start),
        .i_dx    (w_dx),
        .i_dy    (w_dy),
        .o_done  (w_dist_done),
        .o_dist  (w_dist)
    );

    assign w_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_len  = r_len;
        n_sum  = r_sum;
        n_idle = r_idle;
        if (!r_had) begin
            n_len = '0;
        end else if (r_start) begin
            n_idle = sat_add(r_idle, w_dist);
            n_len  = '0;
        end else begin
            n_len = sat_add(r_len, w_dist);
            n_sum = sat_add(r_sum, w_dist);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc_in) begin
                    n_state = r_have_point ? S_DIST : S_DONE;
                end
            end
            S_DIST: begin
                if (w_dist_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_have_point <= 1'b0;
            r_last_x     <= '0;
            r_last_y     <= '0;
            r_len        <= '0;
            r_sum        <= '0;
            r_idle       <= '0;
            r_out_valid  <= 1'b0;
            r_box[plba_pkg::BoxMinX] <= {1'b0, {(CW-1){1'b1}}};
            r_box[plba_pkg::BoxMaxX] <= {1'b1, {(CW-1){1'b0}}};
            r_box[plba_pkg::BoxMinY] <= {1'b0, {(CW-1){1'b1}}};
            r_box[plba_pkg::BoxMaxY] <= {1'b1, {(CW-1){1'b0}}};
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && i_cfg_index <= plba_pkg::CfgLast) begin
                r_box[i_cfg_index[1:0]] <= i_cfg_data;
            end
            if (w_acc_in) begin
                r_have_point <= 1'b1;
                r_last_x     <= i_in_data.point_x;
                r_last_y     <= i_in_data.point_y;
                if (i_in_data.point_x < r_box[plba_pkg::BoxMinX]) begin
                    r_box[plba_pkg::BoxMinX] <= i_in_data.point_x;
                end
                if (i_in_data.point_x > r_box[plba_pkg::BoxMaxX]) begin
                    r_box[plba_pkg::BoxMaxX] <= i_in_data.point_x;
                end
                if (i_in_data.point_y < r_box[plba_pkg::BoxMinY]) begin
                    r_box[plba_pkg::BoxMinY] <= i_in_data.point_y;
                end
                if (i_in_data.point_y > r_box[plba_pkg::BoxMaxY]) begin
                    r_box[plba_pkg::BoxMaxY] <= i_in_data.point_y;
                end
            end
            if (w_load) begin
                r_len       <= n_len;
                r_sum       <= n_sum;
                r_idle      <= n_idle;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            r_had   <= r_have_point;
            r_start <= i_in_data.curve_start;
        end
        if (w_load) begin
            r_out.current_length <= n_len;
            r_out.curve_total    <= n_sum;
            r_out.idle_total     <= n_idle;
            r_out.box_min_x      <= r_box[plba_pkg::BoxMinX];
            r_out.box_max_x      <= r_box[plba_pkg::BoxMaxX];
            r_out.box_min_y      <= r_box[plba_pkg::BoxMinY];
            r_out.box_max_y      <= r_box[plba_pkg::BoxMaxY];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: rtl/plba_dist.sv
module plba_dist (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [plba_pkg::DiffW-1:0]    i_dx,
    input  logic [plba_pkg::DiffW-1:0]    i_dy,
    output logic                          o_done,
    output logic [plba_pkg::DistW-1:0]    o_dist
);

    localparam int DW   = plba_pkg::DiffW;
    localparam int RW   = plba_pkg::DistW;
    localparam int AW   = 2 * RW;
    localparam int RemW = RW + 2;
    localparam int CntW = $clog2(RW);

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_MUL  = 3'b010,
        D_SQRT = 3'b100
    } t_dstate;

    t_dstate           r_state, n_state;
    logic [CntW-1:0]   r_cnt, n_cnt;
    logic [DW-1:0]     r_a, r_b, r_ma, r_mb, n_ma, n_mb;
    logic [AW-1:0]     r_acc, n_acc;
    logic [RemW-1:0]   r_rem, n_rem;
    logic [RW-1:0]     r_root, n_root;
    logic              r_done, n_done;

    logic [DW:0]       w_part;
    logic [RemW+1:0]   w_rem2, w_trial, w_diff;
    logic              w_ge;

    // squaring: multiplier bits MSB first, both squares share the accumulator
    assign w_part = ({1'b0, (r_ma[DW-1] ? r_a : '0)}) + ({1'b0, (r_mb[DW-1] ? r_b : '0)});

    // root: two radicand bits per step
    assign w_rem2  = {r_rem, r_acc[AW-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_diff  = w_rem2 - w_trial;
    assign w_ge    = (w_rem2 >= w_trial);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ma    = r_ma;
        n_mb    = r_mb;
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_root  = r_root;
        n_done  = 1'b0;
        unique case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_state = D_MUL;
                    n_cnt   = '0;
                    n_ma    = i_dx;
                    n_mb    = i_dy;
                    n_acc   = '0;
                    n_rem   = '0;
                    n_root  = '0;
                end
            end
            D_MUL: begin
                n_acc = {r_acc[AW-2:0], 1'b0} + AW'(w_part);
                n_ma  = {r_ma[DW-2:0], 1'b0};
                n_mb  = {r_mb[DW-2:0], 1'b0};
                if (r_cnt == CntW'(DW - 1)) begin
                    n_cnt   = '0;
                    n_state = D_SQRT;
                end else begin
                    n_cnt = r_cnt + CntW'(1);
                end
            end
            D_SQRT: begin
                n_acc  = {r_acc[AW-3:0], 2'b00};
                n_rem  = w_ge ? w_diff[RemW-1:0] : w_rem2[RemW-1:0];
                n_root = {r_root[RW-2:0], w_ge};
                if (r_cnt == CntW'(RW - 1)) begin
                    n_cnt   = '0;
                    n_state = D_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_cnt = r_cnt + CntW'(1);
                end
            end
            default: begin
                n_state = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == D_IDLE && i_start) begin
            r_a <= i_dx;
            r_b <= i_dy;
        end
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_acc  <= n_acc;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_dist = r_root;

endmodule
